@@ rtl/ladt_pkg.sv @@
// Package for the local alignment block with traceback.
// Holds shared types, direction codes, modes and sizes; depends on nothing.
package ladt_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_ALIGN  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [1:0] DIR_DIAG  = 2'd0;
    localparam logic [1:0] DIR_GAP_A = 2'd1;
    localparam logic [1:0] DIR_GAP_B = 2'd2;
    localparam logic [1:0] DIR_STOP  = 2'd3;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    // Cell scores run from 0 to 960 with positive penalties, and a candidate
    // may dip to -16, so the signed score needs 11 bits.
    localparam int SCORE_W = 11;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [7:0] column_a;
        logic [7:0] column_b;
        logic       column_valid;
        logic       last;
        logic [5:0] match_count;
        logic [6:0] align_length;
        logic [5:0] start_a;
        logic [5:0] start_b;
        logic [5:0] end_a;
        logic [5:0] end_b;
    } out_item_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        to_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

endpackage

@@ rtl/ladt_stream_if.sv @@
// Valid/ready channel interface carrying one payload per transfer.
// Depends on nothing; payload type is a parameter.
interface ladt_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/ladt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module ladt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/local_alignment_dp_traceback.sv @@
// Local alignment (linear gap) with traceback. Load items (mode 0/1) are stored while
// idle. An align item first clears score row zero, then scores the matrix cell by cell,
// each cell in a read step for the symbol/score memories and then a step that computes
// and writes back. Traceback then walks the direction memory column by column, a read
// and a check per column, until it reaches the stop, and emission takes a buffer read
// and then an output register per column, held while the output stalls. Load items
// may be taken while the final result of the previous run still waits in the output
// register.
// Depends on ladt_pkg, ladt_stream_if and ladt_ram.
module local_alignment_dp_traceback #(
    parameter int MAX_LEN_A = 32,
    parameter int MAX_LEN_B = 32
) (
    input  logic clk,
    input  logic rst_n,
    ladt_stream_if.sink   in_ch,
    ladt_stream_if.source out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);
    localparam int AW = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
    localparam int BW = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
    localparam int LA_W = $clog2(MAX_LEN_A + 1);
    localparam int LB_W = $clog2(MAX_LEN_B + 1);
    localparam int ROWS = 2 * (MAX_LEN_B + 1);
    localparam int RW = $clog2(ROWS);
    localparam int DEPTH_D = MAX_LEN_A * MAX_LEN_B;
    localparam int DW = (DEPTH_D > 1) ? $clog2(DEPTH_D) : 1;
    localparam int COLS = MAX_LEN_A + MAX_LEN_B;
    localparam int CW = $clog2(COLS + 1);
    localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RD, S_CALC, S_TB_RD, S_TB_CHK, S_EMIT_RD, S_EMIT
    } state_t;

    state_t state_reg;
    logic [3:0] match_reg;
    logic signed [4:0] mism_reg, gap_reg;
    logic [LA_W-1:0] len_a_reg, i_reg;
    logic [LB_W-1:0] len_b_reg, j_reg;
    ladt_pkg::score_t best_reg, left_reg, diag_reg;
    logic [5:0] best_a_reg, best_b_reg, ci_reg, cj_reg;
    logic found_reg;
    logic [CW-1:0] n_reg, k_reg;
    logic [5:0] mcnt_reg;
    ladt_pkg::out_item_t out_reg;
    ladt_pkg::out_item_t out_next;
    logic emit_last;
    logic out_valid_reg;

    // Memory ports.
    logic a_we, b_we, s_we, d_we, c_we;
    logic [AW-1:0] a_waddr, a_raddr;
    logic [BW-1:0] b_waddr, b_raddr;
    logic [7:0] a_rdata, b_rdata;
    logic [RW-1:0] s_waddr, s_raddr;
    ladt_pkg::score_t s_wdata, s_rdata;
    logic [DW-1:0] d_waddr, d_raddr;
    logic [1:0] d_wdata, d_rdata;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [15:0] c_wdata, c_rdata;

    ladt_ram #(.WIDTH(8), .DEPTH(MAX_LEN_A)) u_seq_a (.clk, .we(a_we), .waddr(a_waddr),
        .wdata(in_ch.payload.symbol), .raddr(a_raddr), .rdata(a_rdata));
    ladt_ram #(.WIDTH(8), .DEPTH(MAX_LEN_B)) u_seq_b (.clk, .we(b_we), .waddr(b_waddr),
        .wdata(in_ch.payload.symbol), .raddr(b_raddr), .rdata(b_rdata));
    ladt_ram #(.WIDTH(ladt_pkg::SCORE_W), .DEPTH(ROWS)) u_score (.clk, .we(s_we),
        .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
    ladt_ram #(.WIDTH(2), .DEPTH(DEPTH_D)) u_dir (.clk, .we(d_we), .waddr(d_waddr),
        .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata));
    ladt_ram #(.WIDTH(16), .DEPTH(COLS)) u_cols (.clk, .we(c_we), .waddr(c_waddr),
        .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));

    logic in_fire, out_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    // Row bank of a score row index: row r lives at (r & 1) * (MAX_LEN_B + 1).
    function automatic logic [RW-1:0] srow(input logic rb, input logic [LB_W-1:0] col);
        srow = RW'(rb ? (MAX_LEN_B + 1) : 0) + RW'(col);
    endfunction

    // Cell arithmetic: up from the previous score row in memory, diag and left held in registers.
    ladt_pkg::score_t diag_v, up_v, left_v, sc;
    logic [1:0] act;
    logic eq;
    always_comb
    begin
        eq = a_rdata == b_rdata;
        diag_v = diag_reg + (eq ? ladt_pkg::score_t'({1'b0, match_reg})
                                : ladt_pkg::score_t'(mism_reg));
        up_v = s_rdata + ladt_pkg::score_t'(gap_reg);
        left_v = left_reg + ladt_pkg::score_t'(gap_reg);
        sc = '0;
        act = ladt_pkg::DIR_STOP;
        if (diag_v > sc)
        begin
            sc = diag_v;
            act = ladt_pkg::DIR_DIAG;
        end
        if (up_v > sc)
        begin
            sc = up_v;
            act = ladt_pkg::DIR_GAP_B;
        end
        if (left_v > sc)
        begin
            sc = left_v;
            act = ladt_pkg::DIR_GAP_A;
        end
    end

    logic [7:0] tb_a, tb_b;
    logic tb_eq;
    always_comb
    begin
        tb_eq = a_rdata == b_rdata;
        tb_a = a_rdata;
        tb_b = b_rdata;
        case (d_rdata)
            ladt_pkg::DIR_DIAG:
            begin
                tb_a = tb_eq ? ladt_pkg::to_lower(a_rdata) : ladt_pkg::to_upper(a_rdata);
                tb_b = tb_eq ? ladt_pkg::to_lower(b_rdata) : ladt_pkg::to_upper(b_rdata);
            end
            ladt_pkg::DIR_GAP_A: tb_a = ladt_pkg::CHAR_DASH;
            ladt_pkg::DIR_GAP_B: tb_b = ladt_pkg::CHAR_DASH;
            default: ;
        endcase
    end

    // Next result: the buffered column, if any, with statistics on the final one.
    always_comb
    begin
        emit_last = (n_reg == '0) || (k_reg == n_reg - 1'b1);
        out_next = '0;
        if (n_reg != '0)
        begin
            out_next.column_a = c_rdata[15:8];
            out_next.column_b = c_rdata[7:0];
            out_next.column_valid = 1'b1;
        end
        if (emit_last)
        begin
            out_next.last = 1'b1;
            out_next.match_count = mcnt_reg;
            out_next.align_length = 7'(n_reg);
            out_next.start_a = ci_reg;
            out_next.start_b = cj_reg;
            out_next.end_a = best_a_reg;
            out_next.end_b = best_b_reg;
        end
    end

    // Memory address and write control.
    always_comb
    begin
        a_we = in_fire && in_ch.payload.mode == ladt_pkg::MODE_LOAD_A
            && len_a_reg < LA_W'(MAX_LEN_A);
        b_we = in_fire && in_ch.payload.mode == ladt_pkg::MODE_LOAD_B
            && len_b_reg < LB_W'(MAX_LEN_B);
        a_waddr = len_a_reg[AW-1:0];
        b_waddr = len_b_reg[BW-1:0];
        a_raddr = AW'(i_reg - 1'b1);
        b_raddr = BW'(j_reg - 1'b1);
        if (state_reg == S_TB_RD || state_reg == S_TB_CHK)
        begin
            a_raddr = AW'(ci_reg - 1'b1);
            b_raddr = BW'(cj_reg - 1'b1);
        end
        s_we = (state_reg == S_INIT) || (state_reg == S_CALC);
        s_waddr = srow(i_reg[0], j_reg);
        s_wdata = (state_reg == S_CALC) ? sc : '0;
        s_raddr = srow(~i_reg[0], j_reg);
        d_we = (state_reg == S_CALC);
        d_waddr = DW'(32'(i_reg - 1'b1) * MAX_LEN_B + 32'(j_reg - 1'b1));
        d_raddr = DW'(32'(ci_reg - 1'b1) * MAX_LEN_B + 32'(cj_reg - 1'b1));
        d_wdata = act;
        c_we = (state_reg == S_TB_CHK) && d_rdata != ladt_pkg::DIR_STOP;
        c_waddr = n_reg[CAW-1:0];
        c_wdata = {tb_a, tb_b};
        c_raddr = CAW'(n_reg - 1'b1 - k_reg);
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            match_reg <= 4'd3;
            mism_reg <= -5'sd2;
            gap_reg <= -5'sd2;
            len_a_reg <= '0;
            len_b_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            best_reg <= '0;
            best_a_reg <= '0;
            best_b_reg <= '0;
            found_reg <= 1'b0;
            ci_reg <= '0;
            cj_reg <= '0;
            n_reg <= '0;
            k_reg <= '0;
            mcnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ladt_pkg::REG_MATCH: match_reg <= cfg_data[3:0];
                    ladt_pkg::REG_MISMATCH: mism_reg <= cfg_data;
                    ladt_pkg::REG_GAP: gap_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (a_we)
                    begin
                        len_a_reg <= len_a_reg + 1'b1;
                    end
                    if (b_we)
                    begin
                        len_b_reg <= len_b_reg + 1'b1;
                    end
                    if (in_fire && in_ch.payload.mode == ladt_pkg::MODE_ALIGN)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                        best_reg <= '0;
                        best_a_reg <= '0;
                        best_b_reg <= '0;
                        found_reg <= 1'b0;
                        n_reg <= '0;
                        mcnt_reg <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    // Clear row zero, then start row one, or go straight to traceback if either sequence is empty.
                    if (j_reg == len_b_reg)
                    begin
                        if (len_a_reg == '0 || len_b_reg == '0)
                        begin
                            ci_reg <= '0;
                            cj_reg <= '0;
                            state_reg <= S_TB_RD;
                        end
                        else
                        begin
                            i_reg <= LA_W'(1);
                            j_reg <= LB_W'(1);
                            left_reg <= '0;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_RD:
                begin
                    // Fetch diag = prev[j-1] is the up of the previous cell.
                    if (j_reg == LB_W'(1))
                    begin
                        diag_reg <= '0;
                    end
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (!found_reg || sc > best_reg)
                    begin
                        found_reg <= 1'b1;
                        best_reg <= sc;
                        best_a_reg <= 6'(i_reg);
                        best_b_reg <= 6'(j_reg);
                    end
                    diag_reg <= s_rdata;
                    left_reg <= sc;
                    if (j_reg == len_b_reg)
                    begin
                        if (i_reg == len_a_reg)
                        begin
                            ci_reg <= (!found_reg || sc > best_reg) ? 6'(i_reg) : best_a_reg;
                            cj_reg <= (!found_reg || sc > best_reg) ? 6'(j_reg) : best_b_reg;
                            state_reg <= S_TB_RD;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= LB_W'(1);
                            left_reg <= '0;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_TB_RD:
                begin
                    if (ci_reg == '0 || cj_reg == '0)
                    begin
                        k_reg <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_TB_CHK;
                    end
                end
                S_TB_CHK:
                begin
                    case (d_rdata)
                        ladt_pkg::DIR_DIAG:
                        begin
                            ci_reg <= ci_reg - 1'b1;
                            cj_reg <= cj_reg - 1'b1;
                            if (tb_eq)
                            begin
                                mcnt_reg <= mcnt_reg + 1'b1;
                            end
                        end
                        ladt_pkg::DIR_GAP_A: cj_reg <= cj_reg - 1'b1;
                        ladt_pkg::DIR_GAP_B: ci_reg <= ci_reg - 1'b1;
                        default: ;
                    endcase
                    if (d_rdata == ladt_pkg::DIR_STOP)
                    begin
                        k_reg <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        n_reg <= n_reg + 1'b1;
                        state_reg <= S_TB_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    if (!out_valid_reg || out_fire)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg <= out_next;
                    if (emit_last)
                    begin
                        len_a_reg <= '0;
                        len_b_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_EMIT_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped while stalled");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready)
        else $error("input taken during alignment");
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_a_reg <= LA_W'(MAX_LEN_A) && len_b_reg <= LB_W'(MAX_LEN_B))
        else $error("sequence length overflow");
    a_cols_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(COLS))
        else $error("column count overflow");
`endif
endmodule
